// File: rtl/ale_pkg.sv
// Shared types and constants for the array list engine.
// Holds the command codes and the input and result item structs; no dependencies.
`default_nettype none

package ale_pkg;

    // Default list depth
    localparam int ALE_CAPACITY = 16;

    // Field widths
    localparam int MODE_W  = 3;
    localparam int POS_W   = 5;
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 5;

    // Command codes
    localparam logic [MODE_W-1:0] MODE_INS_AT  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DEL_AT  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_LOCATE  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DEL_ALL = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SORT_IN = 3'd4;
    localparam logic [MODE_W-1:0] MODE_PURGE   = 3'd5;

    // Command item
    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
    } t_in;

    // Result item
    typedef struct packed {
        logic               ok;
        logic [POS_W-1:0]   where;
        logic [COUNT_W-1:0] count_now;
    } t_out;

endpackage

`default_nettype wire

// File: rtl/array_list_engine.sv
// Array list engine: length N, one command item at a time. After acceptance and a decode state,
// insert at p shifts entries up one slot from the top, delete at p streams later entries down,
// locate scans from the front, delete-all-equal compacts, sorted insert checks any last entry and
// then scans, purge runs a compaction pass per entry (one read per entry per pass); the result is
// then registered. The cost is set by the single read and write port of the entry RAM. The next
// item is taken after that. Reset clears the length and control state; the RAM keeps its data.
`default_nettype none

module array_list_engine #(
    parameter int CAPACITY = ale_pkg::ALE_CAPACITY
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output      logic          o_in_stall,
    input  wire ale_pkg::t_in  i_in_item,
    output      logic          o_out_valid,
    input  wire logic          i_out_stall,
    output      ale_pkg::t_out o_out_item
);

    import ale_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int CW = ((LW > POS_W) ? LW : POS_W) + 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_UP,
        S_COMPACT,
        S_FIND,
        S_LAST,
        S_LASTCHK,
        S_PKEY,
        S_PKEY2,
        S_DONE
    } t_state;

    // Control and payload registers
    t_state                   r_state, n_state;
    logic [MODE_W-1:0]        r_mode, n_mode;
    logic [POS_W-1:0]         r_pos, n_pos;
    logic signed [DATA_W-1:0] r_key, n_key;
    logic [LW-1:0]            r_len, n_len;
    logic [LW-1:0]            r_idx, n_idx;
    logic [LW-1:0]            r_wp, n_wp;
    logic [LW-1:0]            r_ins, n_ins;
    logic [LW-1:0]            r_pi, n_pi;
    logic                     r_ok, n_ok;
    logic [CW-1:0]            r_where, n_where;
    logic                     r_rd_vld;
    logic [AW-1:0]            r_rd_addr;
    logic                     r_out_valid, n_out_valid;
    t_out                     r_out_item, n_out_item;

    // RAM port signals
    logic                     rd_en;
    logic [AW-1:0]            rd_addr;
    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic signed [DATA_W-1:0] wr_data;
    logic signed [DATA_W-1:0] rd_data;

    // Decode helpers
    logic          accept;
    logic [CW-1:0] len_x;
    logic [CW-1:0] pos_x;
    logic [CW-1:0] cap_x;
    logic [CW-1:0] rd_addr_x;
    logic          is_sort;
    logic          is_track;
    logic          is_purge;
    logic          is_filter;
    logic          drop;
    logic          hit;

    ale_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    assign len_x     = CW'(r_len);
    assign pos_x     = CW'(r_pos);
    assign cap_x     = CW'(CAPACITY);
    assign rd_addr_x = CW'(r_rd_addr);
    assign is_sort   = (r_mode == MODE_SORT_IN);
    assign is_track  = (r_mode == MODE_DEL_ALL);
    assign is_purge  = (r_mode == MODE_PURGE);
    assign is_filter = (r_mode != MODE_DEL_AT);

    // Compaction drops matches except in delete-at; a scan stops on a match or first greater entry
    assign drop = is_filter && (rd_data == r_key);
    assign hit  = r_rd_vld && (is_sort ? (r_key < rd_data) : (r_key == rd_data));

    // Next-state and RAM control
    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_pos       = r_pos;
        n_key       = r_key;
        n_len       = r_len;
        n_idx       = r_idx;
        n_wp        = r_wp;
        n_ins       = r_ins;
        n_pi        = r_pi;
        n_ok        = r_ok;
        n_where     = r_where;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_item  = r_out_item;
        rd_en       = 1'b0;
        rd_addr     = AW'(r_idx);
        wr_en       = 1'b0;
        wr_addr     = AW'(r_wp);
        wr_data     = rd_data;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_mode  = i_in_item.mode;
                    n_pos   = i_in_item.position;
                    n_key   = i_in_item.value;
                    n_ok    = 1'b0;
                    n_where = '0;
                    n_state = S_DECODE;
                end
            end

            S_DECODE: begin
                n_state = S_DONE;
                unique case (r_mode)
                    MODE_INS_AT: begin
                        if (len_x < cap_x && pos_x >= CW'(1) && pos_x <= len_x + CW'(1)) begin
                            n_ok    = 1'b1;
                            n_where = pos_x;
                            n_ins   = LW'(pos_x - CW'(1));
                            n_idx   = r_len;
                            n_state = S_UP;
                        end
                    end
                    MODE_DEL_AT: begin
                        if (pos_x >= CW'(1) && pos_x <= len_x) begin
                            n_ok    = 1'b1;
                            n_where = pos_x;
                            n_idx   = LW'(pos_x);
                            n_wp    = LW'(pos_x - CW'(1));
                            n_state = S_COMPACT;
                        end
                    end
                    MODE_LOCATE: begin
                        n_idx   = '0;
                        n_state = S_FIND;
                    end
                    MODE_DEL_ALL: begin
                        n_idx   = '0;
                        n_wp    = '0;
                        n_state = S_COMPACT;
                    end
                    MODE_SORT_IN: begin
                        if (len_x < cap_x) begin
                            if (r_len == '0) begin
                                n_ok    = 1'b1;
                                n_where = CW'(1);
                                n_ins   = '0;
                                n_idx   = '0;
                                n_state = S_UP;
                            end else begin
                                n_state = S_LAST;
                            end
                        end
                    end
                    MODE_PURGE: begin
                        n_ok    = 1'b1;
                        n_pi    = '0;
                        n_state = S_PKEY;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end

            // Move entries up one slot from the top, then drop the value in
            S_UP: begin
                if (r_rd_vld) begin
                    wr_en   = 1'b1;
                    wr_addr = r_rd_addr + 1'b1;
                    wr_data = rd_data;
                end
                if (r_idx > r_ins) begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(r_idx - 1'b1);
                    n_idx   = r_idx - 1'b1;
                end else if (!r_rd_vld) begin
                    wr_en   = 1'b1;
                    wr_addr = AW'(r_ins);
                    wr_data = r_key;
                    n_len   = r_len + 1'b1;
                    n_state = S_DONE;
                end
            end

            // Stream entries down to the write pointer, dropping matches
            S_COMPACT: begin
                if (r_rd_vld) begin
                    if (!drop) begin
                        wr_en   = 1'b1;
                        wr_addr = AW'(r_wp);
                        wr_data = rd_data;
                        n_wp    = r_wp + 1'b1;
                    end else if (is_track && !r_ok) begin
                        n_ok    = 1'b1;
                        n_where = rd_addr_x + CW'(1);
                    end
                end
                if (r_idx < r_len) begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(r_idx);
                    n_idx   = r_idx + 1'b1;
                end else if (!r_rd_vld) begin
                    n_len = r_wp;
                    if (is_purge) begin
                        n_pi    = r_pi + 1'b1;
                        n_state = S_PKEY;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end

            // Scan from the front for a match or the first greater entry
            S_FIND: begin
                if (hit) begin
                    n_ok    = 1'b1;
                    n_where = rd_addr_x + CW'(1);
                    if (is_sort) begin
                        n_ins   = LW'(r_rd_addr);
                        n_idx   = r_len;
                        n_state = S_UP;
                    end else begin
                        n_state = S_DONE;
                    end
                end else if (r_idx < r_len) begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(r_idx);
                    n_idx   = r_idx + 1'b1;
                end else if (!r_rd_vld) begin
                    if (is_sort) begin
                        n_ok    = 1'b1;
                        n_where = len_x + CW'(1);
                        n_ins   = r_len;
                        n_idx   = r_len;
                        n_state = S_UP;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end

            // Fetch the last entry for the sorted-insert append check
            S_LAST: begin
                rd_en   = 1'b1;
                rd_addr = AW'(r_len - 1'b1);
                n_state = S_LASTCHK;
            end

            S_LASTCHK: begin
                if (r_key >= rd_data) begin
                    n_ok    = 1'b1;
                    n_where = len_x + CW'(1);
                    n_ins   = r_len;
                    n_idx   = r_len;
                    n_state = S_UP;
                end else begin
                    n_idx   = '0;
                    n_state = S_FIND;
                end
            end

            // Fetch the key of the next purge pass
            S_PKEY: begin
                if (CW'(r_pi) + CW'(1) < len_x) begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(r_pi);
                    n_state = S_PKEY2;
                end else begin
                    n_state = S_DONE;
                end
            end

            S_PKEY2: begin
                n_key   = rd_data;
                n_idx   = r_pi + 1'b1;
                n_wp    = r_pi + 1'b1;
                n_state = S_COMPACT;
            end

            // Hand the result to the output register once it is free
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid          = 1'b1;
                    n_out_item.ok        = r_ok;
                    n_out_item.where     = r_where[POS_W-1:0];
                    n_out_item.count_now = len_x[COUNT_W-1:0];
                    n_state              = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, pointers and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_ok        <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_ok        <= n_ok;
            r_rd_vld    <= rd_en;
            r_out_valid <= n_out_valid;
        end
        r_mode     <= n_mode;
        r_pos      <= n_pos;
        r_key      <= n_key;
        r_idx      <= n_idx;
        r_wp       <= n_wp;
        r_ins      <= n_ins;
        r_pi       <= n_pi;
        r_where    <= n_where;
        r_rd_addr  <= rd_addr;
        r_out_item <= n_out_item;
    end

    // The list never grows past its depth
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(r_len) <= cap_x)
        else $error("list length above capacity");

    // A write never lands on the entry being read in the same cycle
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("read and write on the same entry");

    // Compaction writes never overtake its reads
    a_wp_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMPACT) |-> (r_wp <= r_idx))
        else $error("compaction write pointer ahead of read pointer");

    // The length only changes at the end of a shift or a compaction pass
    a_len_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_len != $past(r_len)) |-> (r_state == S_DONE || r_state == S_PKEY))
        else $error("length changed outside a pass end");

endmodule

`default_nettype wire

// File: rtl/ale_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used by the array list engine for the entry store; no dependencies.
`default_nettype none

module ale_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output      logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write, then register the read data
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire
